// ----- hw/rtl/tdrt_pkg.sv -----
// ----------------------------------------------------------------------------
// tdrt_pkg
// Types and codes shared by the Thumb decode and register tracker.
// ----------------------------------------------------------------------------
package tdrt_pkg;

   typedef struct packed {
      logic [31:0] instr_address;
      logic [15:0] first_halfword;
      logic [15:0] second_halfword;
   } req_type;

   typedef struct packed {
      logic [4:0]  instr_class;
      logic [2:0]  instr_length;
      logic [3:0]  sub_operation;
      logic [3:0]  cond_code;
      logic [3:0]  target_reg;
      logic [31:0] reported_value;
      logic        value_valid;
      logic [1:0]  mem_kind;
      logic [1:0]  mem_size;
      logic        mem_signed;
      logic [31:0] store_value;
   } rsp_type;

   // instruction formats
   localparam logic [4:0] CLS_COND_BRANCH = 5'd0;
   localparam logic [4:0] CLS_BRANCH      = 5'd1;
   localparam logic [4:0] CLS_LONG_BL     = 5'd2;
   localparam logic [4:0] CLS_BX          = 5'd3;
   localparam logic [4:0] CLS_ADDSUB_REG  = 5'd4;
   localparam logic [4:0] CLS_ADDSUB_IMM3 = 5'd5;
   localparam logic [4:0] CLS_IMM8        = 5'd6;
   localparam logic [4:0] CLS_SHIFT_IMM   = 5'd7;
   localparam logic [4:0] CLS_ALU         = 5'd8;
   localparam logic [4:0] CLS_ADD_PCSP    = 5'd9;
   localparam logic [4:0] CLS_SP_ADJUST   = 5'd10;
   localparam logic [4:0] CLS_HIREG       = 5'd11;
   localparam logic [4:0] CLS_LS_IMM5     = 5'd12;
   localparam logic [4:0] CLS_LS_REG      = 5'd13;
   localparam logic [4:0] CLS_LDR_PC      = 5'd14;
   localparam logic [4:0] CLS_LS_SP       = 5'd15;
   localparam logic [4:0] CLS_LS_MULTI    = 5'd16;
   localparam logic [4:0] CLS_PUSH_POP    = 5'd17;
   localparam logic [4:0] CLS_UNDEFINED   = 5'd18;

   // memory access kinds and sizes
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_LOAD  = 2'd1;
   localparam logic [1:0] MEM_STORE = 2'd2;

   localparam logic [1:0] SZ_BYTE = 2'd0;
   localparam logic [1:0] SZ_HALF = 2'd1;
   localparam logic [1:0] SZ_WORD = 2'd2;

   // ALU register-form opcodes
   localparam logic [3:0] ALU_AND = 4'd0;
   localparam logic [3:0] ALU_EOR = 4'd1;
   localparam logic [3:0] ALU_LSL = 4'd2;
   localparam logic [3:0] ALU_LSR = 4'd3;
   localparam logic [3:0] ALU_ASR = 4'd4;
   localparam logic [3:0] ALU_ADC = 4'd5;
   localparam logic [3:0] ALU_SBC = 4'd6;
   localparam logic [3:0] ALU_ROR = 4'd7;
   localparam logic [3:0] ALU_NEG = 4'd9;
   localparam logic [3:0] ALU_ORR = 4'd12;
   localparam logic [3:0] ALU_MUL = 4'd13;
   localparam logic [3:0] ALU_BIC = 4'd14;
   localparam logic [3:0] ALU_MVN = 4'd15;

   localparam logic [3:0] REG_SP = 4'd13;
   localparam logic [3:0] REG_PC = 4'd15;

   function automatic logic [31:0] size_mask(input logic [1:0] sz);
      logic [31:0] m;
      case (sz)
         SZ_BYTE: m = 32'h0000_00FF;
         SZ_HALF: m = 32'h0000_FFFF;
         default: m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

// ----- hw/rtl/thumb_decode_register_tracker_core.sv -----
// ----------------------------------------------------------------------------
// thumb_decode_register_tracker_core
// Decodes one Thumb instruction (16-bit, or a 32-bit BL/BLX pair) per transaction against tracked regs.
// ----------------------------------------------------------------------------
// Two register stages (input register, then result register); a request
// moves on into the result register when that register is free or being taken.
// Throughput: one transaction per cycle unless the consumer stalls; the
// register file is updated as an instruction leaves the input register,
// so the next instruction sees it straight away. Reset clears the register
// file and both pipeline valid flags; no clearing pass is needed.
module thumb_decode_register_tracker_core
   import tdrt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   // pipeline registers
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   // tracked registers r0..r14; r15 always reads as pc
   logic [31:0] rf_ff [15];
   logic [31:0] rf_in [15];
   logic [31:0] rv    [16];

   logic advance, fire;

   // decode fields
   logic [31:0] addr, pc, pc_al;
   logic [15:0] h, h2;
   logic [2:0]  rd, rn, rm3;
   logic [4:0]  top5;

   // write-back controls
   logic        wr_en, clr_r0;
   logic [3:0]  wr_idx;
   logic [31:0] wr_val;

   // scratch
   logic [31:0] op_a, op_b, res;
   logic [7:0]  amt;
   logic [2:0]  op3;
   logic [3:0]  hd;
   logic [63:0] rot;

   // hold the result while the consumer stalls, advance otherwise
   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   assign addr  = in_data_ff.instr_address;
   assign h     = in_data_ff.first_halfword;
   assign h2    = in_data_ff.second_halfword;
   assign pc    = addr + 32'd4;
   assign pc_al = {pc[31:2], 2'b00};
   assign rd    = h[2:0];
   assign rn    = h[5:3];
   assign rm3   = h[8:6];
   assign top5  = h[15:11];

   always_comb begin
      for (int i = 0; i < 15; i++) begin
         rv[i] = rf_ff[i];
      end
      rv[15] = pc;
   end

   // decode and execute: one pass over the instruction in the input register
   always_comb begin
      out_data_in = '0;
      out_data_in.instr_class  = CLS_UNDEFINED;
      out_data_in.instr_length = 3'd2;
      wr_en  = 1'b0;
      clr_r0 = 1'b0;
      wr_idx = 4'd0;
      wr_val = 32'd0;
      op_a   = 32'd0;
      op_b   = 32'd0;
      res    = 32'd0;
      amt    = 8'd0;
      op3    = 3'd0;
      hd     = 4'd0;
      rot    = 64'd0;

      if (h[15:12] == 4'hD) begin
         out_data_in.instr_class    = CLS_COND_BRANCH;
         out_data_in.cond_code      = h[11:8];
         out_data_in.reported_value = pc + {{23{h[7]}}, h[7:0], 1'b0};
         out_data_in.value_valid    = 1'b1;
      end else if (h[15:13] == 3'b111 && !h[11]) begin
         if (!h[12]) begin
            out_data_in.instr_class    = CLS_BRANCH;
            out_data_in.reported_value = pc + {{20{h[10]}}, h[10:0], 1'b0};
            out_data_in.value_valid    = 1'b1;
         end else begin
            out_data_in.instr_class  = CLS_LONG_BL;
            out_data_in.instr_length = 3'd4;
            clr_r0 = 1'b1;
            if (h2[15:13] == 3'b111 && h2[11]) begin
               res = pc + {{9{h[10]}}, h[10:0], h2[10:0], 1'b0};
               out_data_in.sub_operation = {3'b000, h2[12]};
               // blx switches to ARM state: align the target down to a word
               out_data_in.reported_value = h2[12] ? res : {res[31:2], 2'b00};
               out_data_in.value_valid    = 1'b1;
            end else begin
               out_data_in.sub_operation = 4'd2;
            end
         end
      end else if (h[15:8] == 8'h47) begin
         out_data_in.instr_class    = CLS_BX;
         out_data_in.sub_operation  = {3'b000, h[7]};
         out_data_in.target_reg     = h[6:3];
         out_data_in.reported_value = rv[h[6:3]];
         out_data_in.value_valid    = 1'b1;
         clr_r0 = 1'b1;
      end else if (h[15:11] == 5'b00011) begin
         op_b = h[10] ? {29'd0, rm3} : rv[{1'b0, rm3}];
         res  = h[9] ? rv[{1'b0, rn}] - op_b : rv[{1'b0, rn}] + op_b;
         out_data_in.instr_class    = h[10] ? CLS_ADDSUB_IMM3 : CLS_ADDSUB_REG;
         out_data_in.sub_operation  = {3'b000, h[9]};
         out_data_in.target_reg     = {1'b0, rd};
         out_data_in.reported_value = res;
         out_data_in.value_valid    = 1'b1;
         wr_en = 1'b1; wr_idx = {1'b0, rd}; wr_val = res;
      end else if (h[15:13] == 3'b001) begin
         op_a = rv[{1'b0, h[10:8]}];
         case (h[12:11])
            2'd0:    res = {24'd0, h[7:0]};
            2'd2:    res = op_a + {24'd0, h[7:0]};
            2'd3:    res = op_a - {24'd0, h[7:0]};
            default: res = op_a;
         endcase
         out_data_in.instr_class    = CLS_IMM8;
         out_data_in.sub_operation  = {2'b00, h[12:11]};
         out_data_in.target_reg     = {1'b0, h[10:8]};
         out_data_in.reported_value = res;
         out_data_in.value_valid    = 1'b1;
         wr_en = (h[12:11] != 2'd1); wr_idx = {1'b0, h[10:8]}; wr_val = res;
      end else if (h[15:13] == 3'b000) begin
         op_a = rv[{1'b0, rn}];
         case (h[12:11])
            2'd0:    res = op_a << h[10:6];
            // a zero shift field encodes a shift by 32
            2'd1:    res = (h[10:6] == 5'd0) ? 32'd0 : op_a >> h[10:6];
            default: res = (h[10:6] == 5'd0) ? {32{op_a[31]}}
                                             : 32'($signed(op_a) >>> h[10:6]);
         endcase
         out_data_in.instr_class    = CLS_SHIFT_IMM;
         out_data_in.sub_operation  = {2'b00, h[12:11]};
         out_data_in.target_reg     = {1'b0, rd};
         out_data_in.reported_value = res;
         out_data_in.value_valid    = 1'b1;
         wr_en = 1'b1; wr_idx = {1'b0, rd}; wr_val = res;
      end else if (h[15:10] == 6'b010000) begin
         op_a = rv[{1'b0, rd}];
         op_b = rv[{1'b0, rn}];
         amt  = op_b[7:0];
         rot  = {op_a, op_a} >> amt[4:0];
         wr_en = 1'b1;
         case (h[9:6])
            ALU_AND: res = op_a & op_b;
            ALU_EOR: res = op_a ^ op_b;
            ALU_LSL: res = (amt >= 8'd32) ? 32'd0 : op_a << amt[4:0];
            ALU_LSR: res = (amt >= 8'd32) ? 32'd0 : op_a >> amt[4:0];
            ALU_ASR: res = (amt >= 8'd32) ? {32{op_a[31]}}
                                          : 32'($signed(op_a) >>> amt[4:0]);
            ALU_ADC: res = op_a + op_b;
            ALU_SBC: res = op_a - op_b;
            ALU_ROR: res = rot[31:0];
            ALU_NEG: res = 32'd0 - op_b;
            ALU_ORR: res = op_a | op_b;
            ALU_MUL: res = 32'(op_a * op_b);
            ALU_BIC: res = op_a & ~op_b;
            ALU_MVN: res = ~op_b;
            default: begin
               // compare forms: nothing written, report the first register
               res   = op_a;
               wr_en = 1'b0;
            end
         endcase
         out_data_in.instr_class    = CLS_ALU;
         out_data_in.sub_operation  = h[9:6];
         out_data_in.target_reg     = {1'b0, rd};
         out_data_in.reported_value = res;
         out_data_in.value_valid    = 1'b1;
         wr_idx = {1'b0, rd}; wr_val = res;
      end else if (h[15:12] == 4'hA) begin
         res = (h[11] ? rv[REG_SP] : pc_al) + {22'd0, h[7:0], 2'b00};
         out_data_in.instr_class    = CLS_ADD_PCSP;
         out_data_in.sub_operation  = {3'b000, h[11]};
         out_data_in.target_reg     = {1'b0, h[10:8]};
         out_data_in.reported_value = res;
         out_data_in.value_valid    = 1'b1;
         wr_en = 1'b1; wr_idx = {1'b0, h[10:8]}; wr_val = res;
      end else if (h[15:8] == 8'hB0) begin
         res = h[7] ? rv[REG_SP] - {23'd0, h[6:0], 2'b00}
                    : rv[REG_SP] + {23'd0, h[6:0], 2'b00};
         out_data_in.instr_class    = CLS_SP_ADJUST;
         out_data_in.sub_operation  = {3'b000, h[7]};
         out_data_in.target_reg     = REG_SP;
         out_data_in.reported_value = res;
         out_data_in.value_valid    = 1'b1;
         wr_en = 1'b1; wr_idx = REG_SP; wr_val = res;
      end else if (h[15:10] == 6'b010001) begin
         hd   = {h[7], rd};
         op_a = rv[hd];
         op_b = rv[h[6:3]];
         out_data_in.instr_class   = CLS_HIREG;
         out_data_in.sub_operation = {2'b00, h[9:8]};
         out_data_in.target_reg    = hd;
         case (h[9:8])
            2'd0:    res = op_a + op_b;
            2'd2:    res = op_b;
            default: res = op_a;
         endcase
         if (hd != REG_PC) begin
            out_data_in.reported_value = res;
            out_data_in.value_valid    = 1'b1;
            wr_en = (h[9:8] == 2'd0) || (h[9:8] == 2'd2);
         end else begin
            // drop the write to pc, still report what it would have been
            out_data_in.reported_value = (h[9:8] == 2'd1) ? 32'd0 : res;
            out_data_in.value_valid    = (h[9:8] == 2'd0) || (h[9:8] == 2'd2);
         end
         wr_idx = hd; wr_val = res;
      end else if (top5 >= 5'd12 && top5 <= 5'd17) begin
         op3 = 3'(top5 - 5'd12);
         out_data_in.instr_class   = CLS_LS_IMM5;
         out_data_in.sub_operation = {1'b0, op3};
         out_data_in.target_reg    = {1'b0, rd};
         out_data_in.value_valid   = 1'b1;
         case (op3[2:1])
            2'd0:    out_data_in.mem_size = SZ_WORD;
            2'd1:    out_data_in.mem_size = SZ_BYTE;
            default: out_data_in.mem_size = SZ_HALF;
         endcase
         out_data_in.mem_kind = op3[0] ? MEM_LOAD : MEM_STORE;
         out_data_in.reported_value = rv[{1'b0, rn}]
            + ({27'd0, h[10:6]} << out_data_in.mem_size);
         if (!op3[0]) begin
            out_data_in.store_value = rv[{1'b0, rd}]
                                      & size_mask(out_data_in.mem_size);
         end
      end else if (h[15:12] == 4'h5) begin
         op3 = h[11:9];
         out_data_in.instr_class   = CLS_LS_REG;
         out_data_in.sub_operation = {1'b0, op3};
         out_data_in.target_reg    = {1'b0, rd};
         out_data_in.value_valid   = 1'b1;
         case (op3)
            3'd0, 3'd4:       out_data_in.mem_size = SZ_WORD;
            3'd1, 3'd5, 3'd7: out_data_in.mem_size = SZ_HALF;
            default:          out_data_in.mem_size = SZ_BYTE;
         endcase
         out_data_in.mem_signed = (op3 == 3'd3) || (op3 == 3'd7);
         out_data_in.mem_kind   = (op3 >= 3'd3) ? MEM_LOAD : MEM_STORE;
         out_data_in.reported_value = rv[{1'b0, rn}] + rv[{1'b0, rm3}];
         if (op3 < 3'd3) begin
            out_data_in.store_value = rv[{1'b0, rd}]
                                      & size_mask(out_data_in.mem_size);
         end
      end else if (h[15:11] == 5'b01001) begin
         out_data_in.instr_class    = CLS_LDR_PC;
         out_data_in.mem_kind       = MEM_LOAD;
         out_data_in.mem_size       = SZ_WORD;
         out_data_in.target_reg     = {1'b0, h[10:8]};
         out_data_in.reported_value = pc_al + {22'd0, h[7:0], 2'b00};
         out_data_in.value_valid    = 1'b1;
      end else if (h[15:12] == 4'h9) begin
         out_data_in.instr_class    = CLS_LS_SP;
         out_data_in.sub_operation  = {3'b000, h[11]};
         out_data_in.mem_kind       = h[11] ? MEM_LOAD : MEM_STORE;
         out_data_in.mem_size       = SZ_WORD;
         out_data_in.target_reg     = {1'b0, h[10:8]};
         out_data_in.reported_value = rv[REG_SP] + {22'd0, h[7:0], 2'b00};
         out_data_in.value_valid    = 1'b1;
         out_data_in.store_value    = h[11] ? 32'd0 : rv[{1'b0, h[10:8]}];
      end else if (h[15:12] == 4'hC) begin
         out_data_in.instr_class    = CLS_LS_MULTI;
         out_data_in.sub_operation  = {3'b000, h[11]};
         out_data_in.mem_kind       = h[11] ? MEM_LOAD : MEM_STORE;
         out_data_in.mem_size       = SZ_WORD;
         out_data_in.target_reg     = {1'b0, h[10:8]};
         out_data_in.reported_value = rv[{1'b0, h[10:8]}];
         out_data_in.value_valid    = 1'b1;
      end else if (h[15:12] == 4'hB && h[10:9] == 2'b10) begin
         out_data_in.instr_class    = CLS_PUSH_POP;
         out_data_in.sub_operation  = {2'b00, h[11], h[8]};
         out_data_in.mem_kind       = h[11] ? MEM_LOAD : MEM_STORE;
         out_data_in.mem_size       = SZ_WORD;
         out_data_in.target_reg     = REG_SP;
         out_data_in.reported_value = rv[REG_SP];
         out_data_in.value_valid    = 1'b1;
      end
   end

   // register file next state: clear r0 for long branch-with-link and bx/blx
   // forms, then the single data write (never to pc)
   always_comb begin
      for (int i = 0; i < 15; i++) begin
         rf_in[i] = rf_ff[i];
      end
      if (fire) begin
         if (clr_r0) begin
            rf_in[0] = 32'd0;
         end
         if (wr_en && wr_idx != REG_PC) begin
            rf_in[wr_idx] = wr_val;
         end
      end
   end

   always_comb begin
      in_valid_in = req_ready ? req_valid : in_valid_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 15; i++) begin
            rf_ff[i] <= 32'd0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < 15; i++) begin
            rf_ff[i] <= rf_in[i];
         end
      end
   end

   // payload registers: capture on acceptance, advance with the pipeline
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives Thumb instructions into the decode and register tracker, predicts
// each decoded result against its own shadow register file and compares
// every field of every response in order.
// ----------------------------------------------------------------------------
module testbench;
   import tdrt_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   thumb_decode_register_tracker_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   // shadow copy of the tracked registers
   logic [31:0] shadow_regs [16];
   rsp_type     pending_decodes [$];
   bit          failed;
   int          hold_off_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [31:0] sign_extend(input logic [31:0] v, input int bits);
      logic [31:0] s;
      s = 32'd1 << (bits - 1);
      v = v & ((s << 1) - 1);
      return (v ^ s) - s;
   endfunction

   function automatic logic [31:0] shift_arith(input logic [31:0] v, input logic [31:0] n);
      if (n >= 32) return v[31] ? 32'hFFFF_FFFF : 32'd0;
      return $signed(v) >>> n;
   endfunction

   function automatic logic [31:0] mask_for(input logic [1:0] sz);
      return sz == SZ_BYTE ? 32'hFF : (sz == SZ_HALF ? 32'hFFFF : 32'hFFFF_FFFF);
   endfunction

   // decode one instruction and advance the shadow registers
   function automatic rsp_type decode_thumb(input req_type q);
      rsp_type     e;
      logic [15:0] h, h2;
      logic [31:0] pc, disp, imm, a, b, n, res, s;
      logic [2:0]  rd, rn, rm3, d;
      logic [3:0]  m, dh;
      logic [4:0]  top5;
      logic [2:0]  op;
      bit          wr;
      h = q.first_halfword;
      h2 = q.second_halfword;
      pc = q.instr_address + 32'd4;
      rd = h[2:0]; rn = h[5:3]; rm3 = h[8:6]; top5 = h[15:11];
      e = '0;
      e.instr_class = CLS_UNDEFINED;
      e.instr_length = 3'd2;
      shadow_regs[15] = pc;
      if (h[15:12] == 4'hD) begin
         e.instr_class = CLS_COND_BRANCH;
         e.cond_code = h[11:8];
         e.reported_value = pc + (sign_extend({24'd0, h[7:0]}, 8) << 1);
         e.value_valid = 1'b1;
      end else if ((h & 16'hE800) == 16'hE000) begin
         disp = sign_extend({21'd0, h[10:0]}, 11);
         if (!h[12]) begin
            e.instr_class = CLS_BRANCH;
            e.reported_value = pc + (disp << 1);
            e.value_valid = 1'b1;
         end else begin
            e.instr_class = CLS_LONG_BL;
            e.instr_length = 3'd4;
            if ((h2 & 16'hE800) == 16'hE800) begin
               e.sub_operation = h2[12] ? 4'd1 : 4'd0;
               e.reported_value = pc + ((disp << 12) | ({21'd0, h2[10:0]} << 1));
               if (!h2[12]) e.reported_value[1:0] = 2'b00;
               e.value_valid = 1'b1;
            end else begin
               e.sub_operation = 4'd2;
            end
            shadow_regs[0] = '0;
         end
      end else if (h[15:8] == 8'h47) begin
         m = h[6:3];
         e.instr_class = CLS_BX;
         e.sub_operation = {3'd0, h[7]};
         e.target_reg = m;
         e.reported_value = shadow_regs[m];
         e.value_valid = 1'b1;
         shadow_regs[0] = '0;
      end else if (h[15:11] == 5'b00011) begin
         b = h[10] ? {29'd0, rm3} : shadow_regs[rm3];
         e.instr_class = h[10] ? CLS_ADDSUB_IMM3 : CLS_ADDSUB_REG;
         e.sub_operation = {3'd0, h[9]};
         shadow_regs[rd] = h[9] ? shadow_regs[rn] - b : shadow_regs[rn] + b;
         e.target_reg = {1'b0, rd};
         e.reported_value = shadow_regs[rd];
         e.value_valid = 1'b1;
      end else if (h[15:13] == 3'b001) begin
         d = h[10:8];
         imm = {24'd0, h[7:0]};
         e.instr_class = CLS_IMM8;
         e.sub_operation = {2'd0, h[12:11]};
         case (h[12:11])
            2'd0: shadow_regs[d] = imm;
            2'd2: shadow_regs[d] = shadow_regs[d] + imm;
            2'd3: shadow_regs[d] = shadow_regs[d] - imm;
            default: ;
         endcase
         e.target_reg = {1'b0, d};
         e.reported_value = shadow_regs[d];
         e.value_valid = 1'b1;
      end else if (h[15:13] == 3'b000) begin
         imm = {27'd0, h[10:6]};
         s = shadow_regs[rn];
         e.instr_class = CLS_SHIFT_IMM;
         e.sub_operation = {2'd0, h[12:11]};
         if (h[12:11] == 2'd0) shadow_regs[rd] = s << imm;
         else if (h[12:11] == 2'd1) shadow_regs[rd] = imm != 0 ? s >> imm : 32'd0;
         else shadow_regs[rd] = shift_arith(s, imm != 0 ? imm : 32'd32);
         e.target_reg = {1'b0, rd};
         e.reported_value = shadow_regs[rd];
         e.value_valid = 1'b1;
      end else if (h[15:10] == 6'b010000) begin
         a = shadow_regs[rd]; b = shadow_regs[rn]; n = {24'd0, b[7:0]};
         res = a; wr = 1'b1;
         e.instr_class = CLS_ALU;
         e.sub_operation = h[9:6];
         case (h[9:6])
            ALU_AND: res = a & b;
            ALU_EOR: res = a ^ b;
            ALU_LSL: res = n >= 32 ? 32'd0 : a << n;
            ALU_LSR: res = n >= 32 ? 32'd0 : a >> n;
            ALU_ASR: res = shift_arith(a, n);
            ALU_ADC: res = a + b;
            ALU_SBC: res = a - b;
            ALU_ROR: res = n[4:0] != 0 ? (a >> n[4:0]) | (a << (32 - n[4:0])) : a;
            ALU_NEG: res = 32'd0 - b;
            ALU_ORR: res = a | b;
            ALU_MUL: res = a * b;
            ALU_BIC: res = a & ~b;
            ALU_MVN: res = ~b;
            default: wr = 1'b0;
         endcase
         if (wr) shadow_regs[rd] = res;
         e.target_reg = {1'b0, rd};
         e.reported_value = shadow_regs[rd];
         e.value_valid = 1'b1;
      end else if (h[15:12] == 4'hA) begin
         d = h[10:8];
         e.instr_class = CLS_ADD_PCSP;
         e.sub_operation = {3'd0, h[11]};
         shadow_regs[d] = (h[11] ? shadow_regs[REG_SP] : {pc[31:2], 2'b00})
                          + ({24'd0, h[7:0]} << 2);
         e.target_reg = {1'b0, d};
         e.reported_value = shadow_regs[d];
         e.value_valid = 1'b1;
      end else if (h[15:8] == 8'hB0) begin
         imm = {25'd0, h[6:0]} << 2;
         e.instr_class = CLS_SP_ADJUST;
         e.sub_operation = {3'd0, h[7]};
         shadow_regs[REG_SP] = h[7] ? shadow_regs[REG_SP] - imm : shadow_regs[REG_SP] + imm;
         e.target_reg = REG_SP;
         e.reported_value = shadow_regs[REG_SP];
         e.value_valid = 1'b1;
      end else if (h[15:10] == 6'b010001) begin
         m = h[6:3];
         dh = {h[7], rd};
         e.instr_class = CLS_HIREG;
         e.sub_operation = {2'd0, h[9:8]};
         e.target_reg = dh;
         if (dh != REG_PC) begin
            if (h[9:8] == 2'd2) shadow_regs[dh] = shadow_regs[m];
            else if (h[9:8] == 2'd0) shadow_regs[dh] = shadow_regs[dh] + shadow_regs[m];
            e.reported_value = shadow_regs[dh];
            e.value_valid = 1'b1;
         end else if (h[9:8] == 2'd2) begin
            e.reported_value = shadow_regs[m];
            e.value_valid = 1'b1;
         end else if (h[9:8] == 2'd0) begin
            e.reported_value = pc + shadow_regs[m];
            e.value_valid = 1'b1;
         end
      end else if (top5 >= 12 && top5 <= 17) begin
         op = 3'(top5 - 5'd12);
         e.instr_class = CLS_LS_IMM5;
         e.sub_operation = {1'b0, op};
         e.mem_size = op[2:1] == 0 ? SZ_WORD : (op[2:1] == 1 ? SZ_BYTE : SZ_HALF);
         e.mem_kind = op[0] ? MEM_LOAD : MEM_STORE;
         e.reported_value = shadow_regs[rn] + ({27'd0, h[10:6]} << e.mem_size);
         if (e.mem_kind == MEM_STORE) e.store_value = shadow_regs[rd] & mask_for(e.mem_size);
         e.target_reg = {1'b0, rd};
         e.value_valid = 1'b1;
      end else if (h[15:12] == 4'h5) begin
         op = h[11:9];
         e.instr_class = CLS_LS_REG;
         e.sub_operation = {1'b0, op};
         case (op)
            3'd0, 3'd4: e.mem_size = SZ_WORD;
            3'd1, 3'd5, 3'd7: e.mem_size = SZ_HALF;
            default: e.mem_size = SZ_BYTE;
         endcase
         e.mem_signed = (op == 3'd3 || op == 3'd7);
         e.mem_kind = op >= 3 ? MEM_LOAD : MEM_STORE;
         e.reported_value = shadow_regs[rn] + shadow_regs[rm3];
         if (e.mem_kind == MEM_STORE) e.store_value = shadow_regs[rd] & mask_for(e.mem_size);
         e.target_reg = {1'b0, rd};
         e.value_valid = 1'b1;
      end else if (h[15:11] == 5'b01001) begin
         e.instr_class = CLS_LDR_PC;
         e.mem_kind = MEM_LOAD;
         e.mem_size = SZ_WORD;
         e.target_reg = {1'b0, h[10:8]};
         e.reported_value = {pc[31:2], 2'b00} + ({24'd0, h[7:0]} << 2);
         e.value_valid = 1'b1;
      end else if (h[15:12] == 4'h9) begin
         d = h[10:8];
         e.instr_class = CLS_LS_SP;
         e.sub_operation = {3'd0, h[11]};
         e.mem_kind = h[11] ? MEM_LOAD : MEM_STORE;
         e.mem_size = SZ_WORD;
         e.target_reg = {1'b0, d};
         e.reported_value = shadow_regs[REG_SP] + ({24'd0, h[7:0]} << 2);
         if (!h[11]) e.store_value = shadow_regs[d];
         e.value_valid = 1'b1;
      end else if (h[15:12] == 4'hC) begin
         e.instr_class = CLS_LS_MULTI;
         e.sub_operation = {3'd0, h[11]};
         e.mem_kind = h[11] ? MEM_LOAD : MEM_STORE;
         e.mem_size = SZ_WORD;
         e.target_reg = {1'b0, h[10:8]};
         e.reported_value = shadow_regs[h[10:8]];
         e.value_valid = 1'b1;
      end else if ((h & 16'hF600) == 16'hB400) begin
         e.instr_class = CLS_PUSH_POP;
         e.sub_operation = {2'd0, h[11], h[8]};
         e.mem_kind = h[11] ? MEM_LOAD : MEM_STORE;
         e.mem_size = SZ_WORD;
         e.target_reg = REG_SP;
         e.reported_value = shadow_regs[REG_SP];
         e.value_valid = 1'b1;
      end
      return e;
   endfunction

   function automatic int random_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   // send one transaction; predict it as it is accepted
   task automatic send_instr(input logic [31:0] addr, input logic [15:0] h,
                             input logic [15:0] h2, input bit gaps);
      int      gap;
      req_type q;
      gap = gaps ? random_gap() : 0;
      if (gaps && $urandom_range(0, 3) == 0) gap = 0;
      q.instr_address = addr;
      q.first_halfword = h;
      q.second_halfword = h2;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_decodes.push_back(decode_thumb(q));
   endtask

   // drop the request and wait for every outstanding response
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
   endtask

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_decodes.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_payload);
            failed = 1'b1;
         end else begin
            e = pending_decodes.pop_front();
            if (rsp_payload !== e) begin
               $display("%0t: mismatch expected %h actual %h", $time, e, rsp_payload);
               failed = 1'b1;
            end
         end
      end
   end

   // receiver back-pressure: random stalls, or a long hold-off on request
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            gap = random_gap() + 1;
            repeat (gap) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic test_directed();
      logic [15:0] list [$];
      list = '{16'h2000, 16'h21FF, 16'h3A05, 16'h3BFF, 16'h1888, 16'h1E4A, 16'h0048,
               16'h0848, 16'h1048, 16'hD07F, 16'hDE80, 16'hDFFF, 16'hE3FF, 16'hE400,
               16'h4770, 16'h47F8, 16'h46FF, 16'h44F8, 16'h45F8, 16'hB0FF, 16'hA9FF,
               16'hA0FF, 16'h4FFF, 16'hBE00, 16'hFFFF};
      foreach (list[i]) send_instr($urandom, list[i], 16'hF800, 1'b0);
      send_instr(32'hFFFF_FFFE, 16'hF7FF, 16'hEFFF, 1'b0);
      send_instr(32'h0, 16'hF400, 16'h0000, 1'b0);
      wait_drained();
   endtask

   task automatic test_alu_ops();
      for (int op = 0; op < 16; op++) begin
         send_instr($urandom, 16'(32'h2100 | $urandom_range(0, 255)), 16'h0, 1'b1);
         send_instr($urandom, 16'(32'h4000 | (op << 6) | (1 << 3) | 2), 16'h0, 1'b1);
         send_instr($urandom, 16'h2120, 16'h0, 1'b1);
         send_instr($urandom, 16'(32'h4000 | (op << 6) | (1 << 3) | 2), 16'h0, 1'b1);
      end
      for (int op = 0; op < 8; op++) begin
         send_instr($urandom, 16'(32'h5000 | (op << 9) | $urandom_range(0, 511)),
                    16'h0, 1'b1);
         send_instr($urandom, 16'(32'h6000 | (op << 11) | $urandom_range(0, 2047)),
                    16'h0, 1'b1);
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_off_cycles = 60;
      repeat (40) send_instr($urandom, 16'($urandom), 16'($urandom), 1'b0);
      wait_drained();
   endtask

   task automatic test_random_stream();
      logic [15:0] h;
      for (int i = 0; i < 850; i++) begin
         h = 16'($urandom);
         // bias towards register-setting forms so values spread
         if ($urandom_range(0, 3) == 0) h = 16'h2000 | (h & 16'h1FFF);
         send_instr($urandom, h,
                    $urandom_range(0, 1) ? 16'($urandom | 32'hE800) : 16'($urandom),
                    1'b1);
      end
      wait_drained();
   endtask

   initial begin
      failed = 1'b0;
      hold_off_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      for (int i = 0; i < 16; i++) shadow_regs[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_alu_ops();
      test_backpressure();
      test_random_stream();
      repeat (20) @(posedge clock);
      if (!failed && pending_decodes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
